[hdl/tactile_rational_calibration_core_defines.svh]
// assertion macros for the tactile calibration core
// expects clk and arst_n in the scope of every use
`ifndef TACTILE_RATIONAL_CALIBRATION_CORE_DEFINES_SVH
`define TACTILE_RATIONAL_CALIBRATION_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define TRC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("trc assertion failed");
`define TRC_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error("trc assertion failed");
`else
`define TRC_ASSERT(lbl, prop)
`define TRC_ASSERT_NEVER(lbl, cond)
`endif
`endif

[hdl/trc_pkg.sv]
// shared constants and types of the tactile calibration core
// no dependencies
`default_nettype none
package trc_pkg;
	localparam int CHANNELS_DEF = 96;
	localparam int CH_W = 7;
	localparam int X_W = 16;
	localparam int A_W = 24;
	localparam int B_W = 32;
	localparam int C_W = 25;
	localparam int VAL_W = 48;
	localparam int DIV_STEPS = 48;
	localparam int N_W = 90;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	typedef struct packed {
		logic signed [A_W-1:0] a;
		logic signed [B_W-1:0] b;
		logic signed [C_W-1:0] c;
	} coef_t;

	typedef struct packed {
		logic vld;
		logic cal;
		logic [X_W-1:0] x;
	} s1_t;

	typedef struct packed {
		logic vld;
		logic pass;
		logic use_div;
		logic neg;
		logic ovf;
		logic [VAL_W-1:0] fix;
	} side_t;

	typedef struct packed {
		side_t side;
		logic [VAL_W-1:0] d;
		logic [N_W-1:0] n;
	} div_in_t;

	typedef struct packed {
		side_t side;
		logic [VAL_W-1:0] d;
		logic [VAL_W-1:0] rem;
		logic [VAL_W-1:0] nq;
	} div_st_t;

	typedef struct packed {
		logic vld;
		logic pass;
		logic [VAL_W-1:0] value;
	} res_t;
endpackage
`default_nettype wire

[hdl/trc_if.sv]
// request and response channels of the tactile calibration core
// depends on trc_pkg
`default_nettype none
interface trc_req_if;
	import trc_pkg::*;
	logic valid;
	logic ready;
	logic action;
	logic [CH_W-1:0] channel;
	logic [X_W-1:0] raw_adc;
	logic signed [A_W-1:0] coef_a;
	logic signed [B_W-1:0] coef_b;
	logic signed [C_W-1:0] coef_c;
	logic entry_present;
	modport source(output valid, action, channel, raw_adc, coef_a, coef_b, coef_c,
		entry_present, input ready);
	modport sink(input valid, action, channel, raw_adc, coef_a, coef_b, coef_c,
		entry_present, output ready);
endinterface

interface trc_rsp_if;
	import trc_pkg::*;
	logic valid;
	logic ready;
	logic signed [VAL_W-1:0] value;
	logic passthrough;
	modport source(output valid, value, passthrough, input ready);
	modport sink(input valid, value, passthrough, output ready);
endinterface
`default_nettype wire

[hdl/trc_coef_mem.sv]
// coefficient memory with per-channel present bits, registered read
// depends on trc_pkg
`default_nettype none
module trc_coef_mem #(
	parameter int CHANNELS = trc_pkg::CHANNELS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic wr,
	input  wire logic rd,
	input  wire logic [trc_pkg::CH_W-1:0] channel,
	input  wire logic [trc_pkg::X_W-1:0] x,
	input  trc_pkg::coef_t wdata,
	input  wire logic present,
	input  wire logic cal_en,
	output trc_pkg::s1_t st_s1,
	output trc_pkg::coef_t coef_s1
);
	import trc_pkg::*;
	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	coef_t mem [CHANNELS];
	logic [CHANNELS-1:0] present_q;
	logic [AW-1:0] addr;
	logic in_range;

	assign addr = AW'(32'(channel));
	assign in_range = 32'(channel) < 32'(CHANNELS);

	always_ff @(posedge clk) begin
		if (wr && in_range)
			mem[addr] <= wdata;
		if (rd)
			coef_s1 <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
		end else if (wr && in_range) begin
			present_q[addr] <= present;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1 <= '0;
		end else if (en) begin
			st_s1.vld <= rd;
			st_s1.cal <= cal_en && in_range && present_q[addr];
			st_s1.x <= x;
		end
	end
endmodule
`default_nettype wire

[hdl/trc_front.sv]
// clamp, denominator and numerator product stages ahead of the divider
// depends on trc_pkg
`default_nettype none
module trc_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  trc_pkg::s1_t st_s1,
	input  trc_pkg::coef_t coef_s1,
	output trc_pkg::div_in_t dv_s5
);
	import trc_pkg::*;

	s1_t st_s2, st_s3, st_s4;
	coef_t coef_s2;
	logic signed [C_W-1:0] xs, xq, xq_s2, c_s3;
	logic [C_W-1:0] mxq, mc;
	logic [B_W-1:0] mb;
	logic signed [48:0] am_s3;
	logic [56:0] p_s3, p_s4;
	logic [32:0] m_s3;
	logic neg_s3, neg_s4, bpos_s3, bpos_s4, cneg_s3, cneg_s4;
	logic signed [48:0] den_s4;
	logic [60:0] pl_s4;
	logic [61:0] ph_s4;
	logic [N_W-1:0] n;
	logic [VAL_W-1:0] pp, bval;
	logic dpos;

	// x in Q.8, clamped to c
	assign xs = $signed({1'b0, st_s1.x, 8'b0});
	assign xq = (xs > coef_s1.c) ? coef_s1.c : xs;

	assign mxq = xq_s2[C_W-1] ? C_W'(-xq_s2) : C_W'(xq_s2);
	assign mb = coef_s2.b[B_W-1] ? B_W'(-coef_s2.b) : B_W'(coef_s2.b);
	assign mc = coef_s2.c[C_W-1] ? C_W'(-coef_s2.c) : C_W'(coef_s2.c);

	assign n = {29'b0, pl_s4} + {ph_s4, 28'b0};
	assign dpos = !den_s4[48] && (den_s4 != '0);
	assign pp = p_s4[55:8];
	assign bval = cneg_s4 ? (48'd0 - pp) : pp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s2 <= '0;
			st_s3 <= '0;
			st_s4 <= '0;
			dv_s5 <= '0;
		end else if (en) begin
			st_s2 <= st_s1;
			st_s3 <= st_s2;
			st_s4 <= st_s3;
			dv_s5.side.vld <= st_s4.vld;
			dv_s5.side.pass <= !st_s4.cal;
			dv_s5.side.use_div <= st_s4.cal && dpos;
			dv_s5.side.neg <= neg_s4;
			dv_s5.side.ovf <= 1'b0;
			if (!st_s4.cal)
				dv_s5.side.fix <= {16'b0, st_s4.x, 16'b0};
			else if (bpos_s4)
				dv_s5.side.fix <= bval;
			else
				dv_s5.side.fix <= '0;
			dv_s5.d <= den_s4[VAL_W-1:0];
			dv_s5.n <= n;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coef_s2 <= coef_s1;
			xq_s2 <= xq;
			// a*x reaches +2^47 when both are at their negative limits
			am_s3 <= coef_s2.a * xq_s2;
			p_s3 <= mb * mc;
			m_s3 <= {mxq, 8'b0};
			c_s3 <= coef_s2.c;
			neg_s3 <= coef_s2.b[B_W-1] ^ coef_s2.c[C_W-1] ^ xq_s2[C_W-1];
			bpos_s3 <= !coef_s2.b[B_W-1] && (coef_s2.b != '0);
			cneg_s3 <= coef_s2.c[C_W-1];
			den_s4 <= 49'($signed({c_s3, 16'b0})) - am_s3;
			pl_s4 <= p_s3[27:0] * m_s3;
			ph_s4 <= p_s3[56:28] * m_s3;
			p_s4 <= p_s3;
			neg_s4 <= neg_s3;
			bpos_s4 <= bpos_s3;
			cneg_s4 <= cneg_s3;
		end
	end
endmodule
`default_nettype wire

[hdl/trc_div.sv]
// pipelined restoring divider, one quotient bit per stage, with saturation
// depends on trc_pkg
`default_nettype none
module trc_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  trc_pkg::div_in_t dv_s5,
	output trc_pkg::res_t res_s
);
	import trc_pkg::*;

	div_st_t dst_s [DIV_STEPS+1];
	logic [VAL_W-1:0] q, lim, mag, sval;
	side_t side_in;

	// quotient overflows 48 bits when the upper numerator part reaches d
	always_comb begin
		side_in = dv_s5.side;
		side_in.ovf = {6'b0, dv_s5.n[N_W-1:VAL_W]} >= dv_s5.d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_s[0] <= '0;
		end else if (en) begin
			dst_s[0].side <= side_in;
			dst_s[0].d <= dv_s5.d;
			dst_s[0].rem <= {6'b0, dv_s5.n[N_W-1:VAL_W]};
			dst_s[0].nq <= dv_s5.n[VAL_W-1:0];
		end
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		logic [VAL_W:0] t;
		logic ge;
		assign t = {dst_s[k-1].rem, dst_s[k-1].nq[VAL_W-1]};
		assign ge = t >= {1'b0, dst_s[k-1].d};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dst_s[k] <= '0;
			end else if (en) begin
				dst_s[k].side <= dst_s[k-1].side;
				dst_s[k].d <= dst_s[k-1].d;
				dst_s[k].rem <= ge ? VAL_W'(t - {1'b0, dst_s[k-1].d}) : t[VAL_W-1:0];
				dst_s[k].nq <= {dst_s[k-1].nq[VAL_W-2:0], ge};
			end
		end
	end

	assign q = dst_s[DIV_STEPS].nq;
	assign lim = dst_s[DIV_STEPS].side.neg ? {1'b1, {(VAL_W-1){1'b0}}}
		: {1'b0, {(VAL_W-1){1'b1}}};
	assign mag = (dst_s[DIV_STEPS].side.ovf || q > lim) ? lim : q;
	assign sval = dst_s[DIV_STEPS].side.neg ? (48'd0 - mag) : mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s <= '0;
		end else if (en) begin
			res_s.vld <= dst_s[DIV_STEPS].side.vld;
			res_s.pass <= dst_s[DIV_STEPS].side.pass;
			res_s.value <= dst_s[DIV_STEPS].side.use_div ? sval : dst_s[DIV_STEPS].side.fix;
		end
	end
endmodule
`default_nettype wire

[hdl/tactile_rational_calibration_core.sv]
// Tactile ADC calibration core: a load word writes one channel's coefficients a, b, c
// and present bit, a sample word returns b*c*x/(c - a*x) in Q32.16 (saturated) or the
// raw reading when calibration is off or the channel has no entry. One word is taken
// every clock cycle while the skid register is empty; a sample passes through the
// five stages of coefficient read, clamp and multiply, a divider load stage, the
// 48-stage restoring divider (one quotient bit per stage), a saturation stage and the
// output register. A result held back by the sink fills a one-word skid register, and
// intake and the whole pipeline stop until it drains. A load is written at acceptance
// and is seen by the very next sample. Loads produce no result. Present bits clear at
// reset.
// depends on trc_pkg, trc_if, trc_coef_mem, trc_front, trc_div
`default_nettype none
`include "tactile_rational_calibration_core_defines.svh"
module tactile_rational_calibration_core #(
	parameter int CHANNELS = trc_pkg::CHANNELS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	trc_req_if.sink req,
	trc_rsp_if.source rsp,
	input  wire logic cfg_write_en,
	input  wire logic cfg_write_data
);
	import trc_pkg::*;

	logic calib_en_q;
	logic en, acc, wr, rd;
	s1_t st_s1;
	coef_t coef_s1, wdata;
	div_in_t dv_s5;
	res_t res_s;
	logic out_vld_q, skid_vld_q;
	logic out_pass_q, skid_pass_q;
	logic [VAL_W-1:0] out_val_q, skid_val_q;

	// the whole pipeline moves unless the skid word is occupied
	assign en = !skid_vld_q;
	assign req.ready = en;
	assign acc = req.valid && en;
	assign wr = acc && (req.action == ACT_LOAD);
	assign rd = acc && (req.action == ACT_SAMPLE);
	assign wdata = '{a: req.coef_a, b: req.coef_b, c: req.coef_c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			calib_en_q <= 1'b0;
		else if (cfg_write_en)
			calib_en_q <= cfg_write_data;
	end

	trc_coef_mem #(.CHANNELS(CHANNELS)) u_mem (
		.clk(clk), .arst_n(arst_n), .en(en), .wr(wr), .rd(rd),
		.channel(req.channel), .x(req.raw_adc), .wdata(wdata),
		.present(req.entry_present), .cal_en(calib_en_q),
		.st_s1(st_s1), .coef_s1(coef_s1)
	);

	trc_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.st_s1(st_s1), .coef_s1(coef_s1), .dv_s5(dv_s5)
	);

	trc_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .dv_s5(dv_s5), .res_s(res_s)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (en) begin
			if (!out_vld_q || rsp.ready)
				out_vld_q <= res_s.vld;
			else if (res_s.vld)
				skid_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!out_vld_q || rsp.ready) begin
				out_val_q <= res_s.value;
				out_pass_q <= res_s.pass;
			end else begin
				skid_val_q <= res_s.value;
				skid_pass_q <= res_s.pass;
			end
		end else if (rsp.ready) begin
			out_val_q <= skid_val_q;
			out_pass_q <= skid_pass_q;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.value = out_val_q;
	assign rsp.passthrough = out_pass_q;

	`TRC_ASSERT_NEVER(a_skid_without_out, skid_vld_q && !out_vld_q)
	`TRC_ASSERT(a_skid_fill_on_stall, $rose(skid_vld_q) |-> $past(out_vld_q && !rsp.ready))
	`TRC_ASSERT(a_skid_drains, skid_vld_q && rsp.ready |=> !skid_vld_q)
endmodule
`default_nettype wire

[tb/sv/tb_tactile_rational_calibration_core.sv]
// self-checking bench for the tactile calibration core: drives load and sample words,
// predicts each calibrated value in wide integer math and checks the response stream
// depends on trc_pkg, trc_if and tactile_rational_calibration_core
`default_nettype none
module tb_tactile_rational_calibration_core;
	timeunit 1ns;
	timeprecision 1ps;
	import trc_pkg::*;

	localparam int N_CH = CHANNELS_DEF;
	localparam int DRAIN_CYCLES = 64;
	localparam int STALL_LIMIT = 5000;
	localparam logic signed [127:0] VAL_HI = (128'sd1 <<< 47) - 1;
	localparam logic signed [127:0] VAL_LO = -(128'sd1 <<< 47);

	typedef struct {
		logic [VAL_W-1:0] value;
		logic pass;
	} cal_word_t;

	logic clk;
	logic arst_n;
	logic cfg_write_en;
	logic cfg_write_data;

	trc_req_if req_if();
	trc_rsp_if rsp_if();

	tactile_rational_calibration_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg_write_en(cfg_write_en),
		.cfg_write_data(cfg_write_data)
	);

	// mirror of the block state
	logic calib_on;
	logic present_bits [N_CH];
	logic signed [A_W-1:0] tab_a [N_CH];
	logic signed [B_W-1:0] tab_b [N_CH];
	logic signed [C_W-1:0] tab_c [N_CH];

	cal_word_t pending_words[$];
	int send_idle_pct;
	int recv_idle_pct;
	int errors;
	int words_sent;
	int samples_checked;
	int curve_hits;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [VAL_W-1:0] clip48(logic signed [127:0] v);
		if (v > VAL_HI)
			v = VAL_HI;
		else if (v < VAL_LO)
			v = VAL_LO;
		return v[VAL_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] rational_curve(logic signed [A_W-1:0] a,
		logic signed [B_W-1:0] b, logic signed [C_W-1:0] c, logic [X_W-1:0] x);
		logic signed [127:0] wa, wb, wc, xq, den;
		wa = a;
		wb = b;
		wc = c;
		xq = 128'(x);
		xq = xq <<< 8;
		if (xq > wc)
			xq = wc;
		den = wc * 128'sd65536 - wa * xq;
		if (den <= 0)
			return (wb > 0) ? clip48((wb * wc) / 128'sd256) : '0;
		if (wb == 0 || wc == 0 || xq == 0)
			return '0;
		return clip48((wb * wc * xq * 128'sd256) / den);
	endfunction

	task automatic predict_word(logic act, logic [CH_W-1:0] ch, logic [X_W-1:0] x,
		logic signed [A_W-1:0] a, logic signed [B_W-1:0] b, logic signed [C_W-1:0] c,
		logic present);
		cal_word_t w;
		if (act == ACT_LOAD) begin
			if (ch < N_CH) begin
				tab_a[ch] = a;
				tab_b[ch] = b;
				tab_c[ch] = c;
				present_bits[ch] = present;
			end
			return;
		end
		if (calib_on && ch < N_CH && present_bits[ch]) begin
			w.value = rational_curve(tab_a[ch], tab_b[ch], tab_c[ch], x);
			w.pass = 1'b0;
			curve_hits++;
		end else begin
			w.value = {16'd0, x, 16'd0};
			w.pass = 1'b1;
		end
		pending_words.insert(pending_words.size(), w);
	endtask

	// called at a rising edge; leaves valid high, the next call or drain_pipeline lowers it
	task automatic send_word(logic act, logic [CH_W-1:0] ch, logic [X_W-1:0] x,
		logic signed [A_W-1:0] a, logic signed [B_W-1:0] b, logic signed [C_W-1:0] c,
		logic present);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.action <= act;
		req_if.channel <= ch;
		req_if.raw_adc <= x;
		req_if.coef_a <= a;
		req_if.coef_b <= b;
		req_if.coef_c <= c;
		req_if.entry_present <= present;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		predict_word(act, ch, x, a, b, c, present);
		words_sent++;
	endtask

	task automatic sample(logic [CH_W-1:0] ch, logic [X_W-1:0] x);
		send_word(ACT_SAMPLE, ch, x, '0, '0, '0, 1'b0);
	endtask

	task automatic load(logic [CH_W-1:0] ch, logic signed [A_W-1:0] a,
		logic signed [B_W-1:0] b, logic signed [C_W-1:0] c, logic present);
		send_word(ACT_LOAD, ch, X_W'($urandom), a, b, c, present);
	endtask

	// loads give no response, so wait out the pipeline after the last sample returns
	task automatic drain_pipeline();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_calib(logic en);
		drain_pipeline();
		cfg_write_en <= 1'b1;
		cfg_write_data <= en;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		calib_on = en;
	endtask

	task automatic random_word();
		logic [CH_W-1:0] ch;
		logic signed [A_W-1:0] a;
		logic signed [B_W-1:0] b;
		logic signed [C_W-1:0] c;
		int r;
		r = $urandom_range(99);
		if (r < 8)
			ch = CH_W'($urandom_range(127, N_CH));
		else if (r < 70)
			ch = CH_W'($urandom_range(15));
		else
			ch = CH_W'($urandom_range(N_CH - 1));
		if ($urandom_range(99) < 30) begin
			if ($urandom_range(1)) begin
				a = A_W'($urandom);
				b = B_W'($urandom);
				c = C_W'($urandom);
			end else begin
				// plausible sensor curve: small a, small positive b, positive c
				a = $signed(24'($urandom_range(1 << 17))) - 24'sd65536;
				b = B_W'($urandom_range(1 << 20));
				c = C_W'($urandom_range(24'hFFFFFF, 24'h10000));
			end
			load(ch, a, b, c, $urandom_range(99) < 85);
		end else
			sample(ch, X_W'($urandom));
	endtask

	task automatic random_phase(int n, int s_idle, int r_idle);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		for (int i = 0; i < n; i++) begin
			if (i == n / 2)
				drain_pipeline();
			random_word();
		end
	endtask

	task automatic test_passthrough();
		sample(0, 16'h0000);
		sample(5, 16'hFFFF);
		load(3, 24'sd65536, 32'sd65536, 25'sd16776960, 1'b1);
		sample(3, 16'h1234);
		sample(CH_W'(N_CH - 1), 16'hAAAA);
		sample(7'h7F, 16'h5555);
	endtask

	task automatic test_curve_corners();
		set_calib(1'b1);
		load(0, 24'sd0, 32'sd65536, 25'sd16776960, 1'b1);
		load(1, 24'sh7FFFFF, 32'sh7FFFFFFF, 25'shFFFFFF, 1'b1);
		load(2, -24'sd8388608, -32'sd2147483648, 25'shFFFFFF, 1'b1);
		load(4, 24'sd1000, 32'sd65536, -25'sd16777216, 1'b1);
		load(6, -24'sd8388608, 32'sh7FFFFFFF, 25'shFFFFFF, 1'b1);
		load(CH_W'(N_CH - 1), 24'sd65535, 32'sd0, 25'sd1000, 1'b1);
		sample(0, 16'h0000);
		sample(0, 16'hFFFF);
		sample(1, 16'hFFFF);
		sample(1, 16'h0001);
		sample(2, 16'hFFFF);
		sample(4, 16'h8000);
		sample(6, 16'hFFFF);
		sample(CH_W'(N_CH - 1), 16'h0100);
		sample(3, 16'h4000);
		// removing an entry falls back to the raw reading
		load(0, 24'sd0, 32'sd65536, 25'sd100, 1'b0);
		sample(0, 16'h00FF);
		// out of range load is dropped
		load(100, 24'sd0, 32'sd65536, 25'sd100, 1'b1);
		sample(100, 16'h0F0F);
	endtask

	task automatic test_random_traffic();
		random_phase(320, 36, 70);
		set_calib(1'b0);
		random_phase(150, 70, 36);
		set_calib(1'b1);
		random_phase(170, 70, 36);
		random_phase(290, 0, 0);
	endtask

	// response side: random stalls and in-order checking
	always @(posedge clk) begin
		cal_word_t w;
		if (rsp_if.valid && rsp_if.ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual value=%h pass=%b",
					$time, rsp_if.value, rsp_if.passthrough);
				errors++;
			end else begin
				w = pending_words.pop_front();
				samples_checked++;
				if (rsp_if.value !== w.value) begin
					$display("%0t: value expected %h actual %h", $time, w.value, rsp_if.value);
					errors++;
				end
				if (rsp_if.passthrough !== w.pass) begin
					$display("%0t: passthrough expected %b actual %b", $time, w.pass,
						rsp_if.passthrough);
					errors++;
				end
			end
		end
		rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
		$display("tactile_rational_calibration_core regression: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_write_data = 1'b0;
		req_if.valid = 1'b0;
		req_if.action = ACT_LOAD;
		req_if.channel = '0;
		req_if.raw_adc = '0;
		req_if.coef_a = '0;
		req_if.coef_b = '0;
		req_if.coef_c = '0;
		req_if.entry_present = 1'b0;
		rsp_if.ready = 1'b0;
		calib_on = 1'b0;
		for (int i = 0; i < N_CH; i++)
			present_bits[i] = 1'b0;
		errors = 0;
		words_sent = 0;
		samples_checked = 0;
		curve_hits = 0;
		send_idle_pct = 36;
		recv_idle_pct = 70;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_passthrough();
		test_curve_corners();
		test_random_traffic();
		drain_pipeline();
		$display("sent %0d words, checked %0d samples (%0d through the curve)", words_sent,
			samples_checked, curve_hits);
		$display("covered pass-through, corner coefficients, entry removal and idle mixes");
		if (errors == 0)
			$display("tactile_rational_calibration_core regression: pass");
		else
			$display("tactile_rational_calibration_core regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
